// File: src/oee_pkg.sv
// shared types and constants for the octal escape encoder
package oee_pkg;

	// character codes
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_BSL     = 8'h5C;
	localparam logic [7:0] CH_DIGIT0  = 8'h30;
	localparam logic [7:0] PRINT_LO   = 8'h21;
	localparam logic [7:0] PRINT_HI   = 8'h7E;

	// capacity register
	localparam logic [12:0] CAP_RESET     = 13'd4096;

	// result status codes
	typedef enum logic [1:0] {
		ST_BYTE = 2'd0,
		ST_OK   = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	// work handed from classifier to expander
	typedef enum logic [2:0] {
		JOB_PLAIN   = 3'd0,
		JOB_BSL2    = 3'd1,
		JOB_BSL_OVF = 3'd2,
		JOB_TERM    = 3'd3,
		JOB_OVF     = 3'd4,
		JOB_ESC     = 3'd5
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] chr;
	} job_t;

	// queue status seen by the expander
	typedef struct packed {
		logic empty;
		job_t head;
	} q_head_t;

endpackage

// File: src/oee_front.sv
// front end: capacity register, budget tracking and request classification
module oee_front #(
	parameter int MAX_LEN = 4096,
	parameter int BW      = 13
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [12:0]          cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 in_first,
	input  logic                 q_full,
	output logic                 push,
	output oee_pkg::job_t        job
);

	localparam int RESET_BUDGET = (4096 > MAX_LEN) ? MAX_LEN : 4096;

	logic [12:0]   capacity_q;
	logic [BW-1:0] budget_q;
	logic          ended_q;
	logic [BW-1:0] budget_d;
	logic          ended_d;
	logic [BW-1:0] reload;
	logic          accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;

	// budget reload saturates at the maximum length
	assign reload = (32'(capacity_q) > 32'(MAX_LEN)) ? BW'(MAX_LEN) : BW'(capacity_q);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= oee_pkg::CAP_RESET;
		end else if (cfg_wen) begin
			capacity_q <= cfg_wdata;
		end
	end

	// classify the request and debit the budget
	always_comb begin
		logic [BW-1:0] b;
		logic          e;
		b        = in_first ? reload : budget_q;
		e        = in_first ? 1'b0 : ended_q;
		budget_d = b;
		ended_d  = e;
		push     = 1'b0;
		job.chr  = in_byte;
		job.kind = oee_pkg::JOB_OVF;
		if (accept && !e) begin
			push = 1'b1;
			priority if (in_byte >= oee_pkg::PRINT_LO && in_byte <= oee_pkg::PRINT_HI) begin
				if (b <= BW'(1)) begin
					job.kind = oee_pkg::JOB_OVF;
					budget_d = '0;
					ended_d  = 1'b1;
				end else if (in_byte != oee_pkg::CH_BSL) begin
					job.kind = oee_pkg::JOB_PLAIN;
					budget_d = b - BW'(1);
				end else if (b == BW'(2)) begin
					// first copy fits, second copy overflows
					job.kind = oee_pkg::JOB_BSL_OVF;
					budget_d = '0;
					ended_d  = 1'b1;
				end else begin
					job.kind = oee_pkg::JOB_BSL2;
					budget_d = b - BW'(2);
				end
			end else if (in_byte == oee_pkg::CH_NUL) begin
				ended_d = 1'b1;
				if (b <= BW'(1)) begin
					job.kind = oee_pkg::JOB_OVF;
					budget_d = '0;
				end else begin
					job.kind = oee_pkg::JOB_TERM;
					budget_d = b - BW'(1);
				end
			end else begin
				if (b <= BW'(4)) begin
					job.kind = oee_pkg::JOB_OVF;
					budget_d = '0;
					ended_d  = 1'b1;
				end else begin
					job.kind = oee_pkg::JOB_ESC;
					budget_d = b - BW'(4);
				end
			end
		end
	end

	// string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BW'(RESET_BUDGET);
			ended_q  <= 1'b1;
		end else if (accept) begin
			budget_q <= budget_d;
			ended_q  <= ended_d;
		end
	end

endmodule

// File: src/oee_queue.sv
// two-entry job queue between classifier and expander
module oee_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  oee_pkg::job_t     push_job,
	output logic              full,
	input  logic              pop,
	output oee_pkg::q_head_t  head
);

	oee_pkg::job_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == 2'd2);
	assign head.empty = (count_q == 2'd0);
	assign head.head  = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && !head.empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

// File: src/oee_back.sv
// back end: expands one job into its result beats behind an output register
module oee_back (
	input  logic              clk,
	input  logic              arst_n,
	input  oee_pkg::q_head_t  head,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [7:0]        out_byte,
	output logic              out_valid,
	output logic [1:0]        status,
	output logic              last
);

	logic [1:0]       beat_q;
	logic             res_valid_q;
	logic [7:0]       byte_q;
	logic             bvalid_q;
	oee_pkg::status_t status_q;
	logic             last_q;
	logic             load;
	logic [7:0]       nb_byte;
	logic             nb_valid;
	oee_pkg::status_t nb_status;
	logic             nb_last;

	assign load = !head.empty && (!res_valid_q || res_ready);
	assign pop  = load && nb_last;

	// next beat of the head job
	always_comb begin
		nb_byte   = head.head.chr;
		nb_valid  = 1'b1;
		nb_status = oee_pkg::ST_BYTE;
		nb_last   = 1'b1;
		unique case (head.head.kind)
			oee_pkg::JOB_PLAIN: begin
				nb_byte = head.head.chr;
			end
			oee_pkg::JOB_BSL2: begin
				nb_byte = oee_pkg::CH_BSL;
				nb_last = (beat_q == 2'd1);
			end
			oee_pkg::JOB_BSL_OVF: begin
				if (beat_q == 2'd0) begin
					nb_byte = oee_pkg::CH_BSL;
					nb_last = 1'b0;
				end else begin
					nb_byte   = oee_pkg::CH_NUL;
					nb_valid  = 1'b0;
					nb_status = oee_pkg::ST_OVF;
				end
			end
			oee_pkg::JOB_TERM: begin
				nb_byte   = oee_pkg::CH_NUL;
				nb_status = oee_pkg::ST_OK;
			end
			oee_pkg::JOB_ESC: begin
				nb_last = (beat_q == 2'd3);
				unique case (beat_q)
					2'd0: nb_byte = oee_pkg::CH_BSL;
					2'd1: nb_byte = oee_pkg::CH_DIGIT0 + {6'd0, head.head.chr[7:6]};
					2'd2: nb_byte = oee_pkg::CH_DIGIT0 + {5'd0, head.head.chr[5:3]};
					default: nb_byte = oee_pkg::CH_DIGIT0 + {5'd0, head.head.chr[2:0]};
				endcase
			end
			default: begin
				// overflow, nothing written
				nb_byte   = oee_pkg::CH_NUL;
				nb_valid  = 1'b0;
				nb_status = oee_pkg::ST_OVF;
			end
		endcase
	end

	// beat counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= 2'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				beat_q      <= nb_last ? 2'd0 : beat_q + 2'd1;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= nb_byte;
			bvalid_q <= nb_valid;
			status_q <= nb_status;
			last_q   <= nb_last;
		end
	end

	assign res_valid = res_valid_q;
	assign out_byte  = byte_q;
	assign out_valid = bvalid_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

// File: src/octal_escape_encoder.sv
// Backslash-octal escape encoder with a per-string output budget. The front end
// accepts one input request per cycle while its two-entry job queue has room,
// reloads and debits the budget and decides the whole outcome of the byte at
// once; the back end turns each job into one to four results, one per cycle
// while the receiver takes them, through a registered output stage. A printable
// byte, terminator or overflow yields one result, a doubled backslash two and an
// octal escape four, so the sustained input rate is set by the result beats the
// expander has to produce. Bytes dropped after the end of a string produce no
// job. A capacity write applies at the next first byte.
module octal_escape_encoder #(
	parameter int MAX_LEN = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [12:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_first,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	output logic [1:0]  status,
	output logic        last
);

	localparam int BW = $clog2(MAX_LEN + 1);

	logic             q_full;
	logic             push;
	oee_pkg::job_t    job;
	logic             pop;
	oee_pkg::q_head_t head;

	// classifier and budget
	oee_front #(
		.MAX_LEN (MAX_LEN),
		.BW      (BW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_first  (in_first),
		.q_full    (q_full),
		.push      (push),
		.job       (job)
	);

	// job queue
	oee_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.full     (q_full),
		.pop      (pop),
		.head     (head)
	);

	// expander and output stage
	oee_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.out_byte  (out_byte),
		.out_valid (out_valid),
		.status    (status),
		.last      (last)
	);

endmodule

// File: src/oee_checker.sv
// port-level checks for the octal escape encoder and their binding
module oee_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] out_byte,
	input logic       out_valid,
	input logic [1:0] status,
	input logic       last
);

	// an overflow writes nothing and closes the request
	a_ovf_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == oee_pkg::ST_OVF |-> !out_valid && out_byte == 8'h00 && last)
		else $error("overflow result carries a byte or is not last");

	// the terminator is a written zero and closes the request
	a_term: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == oee_pkg::ST_OK |-> out_valid && out_byte == 8'h00 && last)
		else $error("terminator result malformed");

	// only an overflow leaves a result unwritten
	a_unwritten: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> status == oee_pkg::ST_OVF)
		else $error("unwritten result without overflow status");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_byte) && $stable(status)
			&& $stable(last) && $stable(out_valid))
		else $error("stalled result changed");

endmodule

bind octal_escape_encoder oee_checker u_oee_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.out_byte  (out_byte),
	.out_valid (out_valid),
	.status    (status),
	.last      (last)
);
